// ----- hw/rtl/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Fixed-point widths, pipeline depths and helpers for the pose to
// quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int ROT_FRAC_BITS = 14;
	localparam int ONE           = 1 << ROT_FRAC_BITS;
	localparam int ROT_W         = 16;
	localparam int TRANS_W       = 32;
	localparam int RAD_W         = 18;
	localparam int SQ_IN_W       = 32;
	localparam int SQ_STEPS      = SQ_IN_W / 2;
	localparam int ROOT_W        = SQ_STEPS;
	localparam int SQ_REM_W      = ROOT_W + 2;
	localparam int DIV_W         = 32;
	localparam int DVS_W         = ROOT_W + 1;
	localparam int LANES         = 3;
	localparam int SAT_W         = DIV_W + 2;

	typedef enum logic [1:0] {
		MAJ_W,
		MAJ_X,
		MAJ_Y,
		MAJ_Z
	} major_t;

	// sideband that travels with each item through the pipe
	typedef struct packed {
		logic signed [TRANS_W-1:0] pos_x;
		logic signed [TRANS_W-1:0] pos_y;
		logic signed [TRANS_W-1:0] pos_z;
		major_t                    major;
		logic                      degen;
		logic [LANES-1:0]          neg;
		logic [ROT_W-1:0]          big;
	} side_t;

	// clamp to the signed 16-bit range
	function automatic logic signed [ROT_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
		logic signed [ROT_W-1:0] r;
		if (v > SAT_W'(32767))
			r = 16'sh7fff;
		else if (v < -SAT_W'(32768))
			r = 16'sh8000;
		else
			r = v[ROT_W-1:0];
		return r;
	endfunction

endpackage

// ----- hw/rtl/rmq_if.sv -----
// ----------------------------------------------------------------------------
// rmq_if: pose and quaternion channels
// Valid/ready channels carrying one pose matrix or one pose result.
// ----------------------------------------------------------------------------
interface rmq_in_if;
	import rmq_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [ROT_W-1:0]   r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [TRANS_W-1:0] trans_x, trans_y, trans_z;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		trans_x, trans_y, trans_z, input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		trans_x, trans_y, trans_z, output ready);
endinterface

interface rmq_out_if;
	import rmq_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [TRANS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [ROT_W-1:0]   quat_w, quat_x, quat_y, quat_z;
	logic                      degenerate;

	modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
		degenerate, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
		degenerate, output ready);
endinterface

// ----- hw/rtl/rmq_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rmq_div_pipe: pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rmq_div_pipe (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rmq_pkg::DIV_W-1:0]  dividend,
	input  logic [rmq_pkg::DVS_W-1:0]  divisor,
	output logic [rmq_pkg::DIV_W-1:0]  quotient
);
	import rmq_pkg::*;

	logic [DIV_W-1:0] dvd_s [0:DIV_W];
	logic [DVS_W-1:0] dvs_s [0:DIV_W];
	logic [DVS_W-1:0] rem_s [0:DIV_W];
	logic [DIV_W-1:0] quo_s [0:DIV_W];

	// input register
	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s[0] <= dividend;
			dvs_s[0] <= divisor;
			rem_s[0] <= '0;
			quo_s[0] <= '0;
		end
	end

	// one quotient bit per stage
	for (genvar i = 0; i < DIV_W; i++) begin : g_step
		logic [DVS_W:0] rem_t;
		logic           take;
		assign rem_t = {rem_s[i], dvd_s[i][DIV_W-1]};
		assign take  = rem_t >= {1'b0, dvs_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? DVS_W'(rem_t - {1'b0, dvs_s[i]}) : DVS_W'(rem_t);
				quo_s[i+1] <= {quo_s[i][DIV_W-2:0], take};
				dvd_s[i+1] <= {dvd_s[i][DIV_W-2:0], 1'b0};
				dvs_s[i+1] <= dvs_s[i];
			end
		end
	end

	assign quotient = quo_s[DIV_W];

endmodule

// ----- hw/rtl/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: pose matrix to position and quaternion
// Four-branch trace method in Q1.14 with a pipelined square root and dividers.
// ----------------------------------------------------------------------------
// One pose matrix is taken per cycle while the output is not stalled, and
// the pipe holds the 16-stage square root and the 32-stage dividers, one
// stage per result bit. The whole pipe advances together whenever the
// output register is empty or being taken, so a stall at the output holds
// every item in place. The translation passes through as the position. When
// the chosen radicand is not positive the identity quaternion is sent with
// degenerate set.
module rotation_matrix_to_quaternion (
	input  logic    clk,
	input  logic    arst_n,
	rmq_in_if.sink  pose,
	rmq_out_if.source result
);
	import rmq_pkg::*;

	localparam logic signed [RAD_W-1:0] ONE_R = RAD_W'(ONE);

	logic en;
	logic out_vld_q;

	// pipe advances when the output slot is free or taken
	assign en         = !out_vld_q || result.ready;
	assign pose.ready = en;

	// stage 1: trace, branch, radicand and off-diagonal terms
	logic signed [RAD_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [RAD_W-1:0] tr, rad_c;
	logic signed [RAD_W-1:0] d_wx, d_wy, d_wz, s_xy, s_xz, s_yz;
	logic signed [RAD_W-1:0] n_c [LANES];
	major_t                  maj_c;

	assign e00 = RAD_W'(pose.r00);
	assign e01 = RAD_W'(pose.r01);
	assign e02 = RAD_W'(pose.r02);
	assign e10 = RAD_W'(pose.r10);
	assign e11 = RAD_W'(pose.r11);
	assign e12 = RAD_W'(pose.r12);
	assign e20 = RAD_W'(pose.r20);
	assign e21 = RAD_W'(pose.r21);
	assign e22 = RAD_W'(pose.r22);
	assign tr  = e00 + e11 + e22;
	assign d_wx = e21 - e12;
	assign d_wy = e02 - e20;
	assign d_wz = e10 - e01;
	assign s_xy = e01 + e10;
	assign s_xz = e02 + e20;
	assign s_yz = e12 + e21;

	always_comb begin
		if (tr > 0) begin
			maj_c  = MAJ_W;
			rad_c  = ONE_R + tr;
			n_c[0] = d_wx;
			n_c[1] = d_wy;
			n_c[2] = d_wz;
		end else if (pose.r00 > pose.r11 && pose.r00 > pose.r22) begin
			maj_c  = MAJ_X;
			rad_c  = ONE_R + e00 - e11 - e22;
			n_c[0] = d_wx;
			n_c[1] = s_xy;
			n_c[2] = s_xz;
		end else if (pose.r11 > pose.r22) begin
			maj_c  = MAJ_Y;
			rad_c  = ONE_R + e11 - e00 - e22;
			n_c[0] = d_wy;
			n_c[1] = s_xy;
			n_c[2] = s_yz;
		end else begin
			maj_c  = MAJ_Z;
			rad_c  = ONE_R + e22 - e00 - e11;
			n_c[0] = d_wz;
			n_c[1] = s_xz;
			n_c[2] = s_yz;
		end
	end

	logic                    vld_s1;
	side_t                   side_s1;
	logic signed [RAD_W-1:0] rad_s1;
	logic signed [RAD_W-1:0] n_s1 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= pose.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.pos_x <= pose.trans_x;
			side_s1.pos_y <= pose.trans_y;
			side_s1.pos_z <= pose.trans_z;
			side_s1.major <= maj_c;
			side_s1.degen <= 1'b0;
			side_s1.neg   <= '0;
			side_s1.big   <= '0;
			rad_s1        <= rad_c;
			for (int k = 0; k < LANES; k++)
				n_s1[k] <= n_c[k];
		end
	end

	// stage 2: degenerate test, sqrt operand, numerator magnitudes
	logic                    sq_vld_s  [0:SQ_STEPS];
	side_t                   sq_side_s [0:SQ_STEPS];
	logic [SQ_IN_W-1:0]      sq_v_s    [0:SQ_STEPS];
	logic [SQ_REM_W-1:0]     sq_rem_s  [0:SQ_STEPS];
	logic [ROOT_W-1:0]       sq_root_s [0:SQ_STEPS];
	logic [DIV_W-1:0]        sq_mag_s  [0:SQ_STEPS][LANES];

	logic                    degen_c;
	logic [LANES-1:0]        neg_c;
	logic signed [RAD_W-1:0] abs_c [LANES];
	side_t                   side_c2;

	assign degen_c = rad_s1 <= 0;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			neg_c[k] = n_s1[k][RAD_W-1];
			abs_c[k] = neg_c[k] ? -n_s1[k] : n_s1[k];
		end
	end

	// sideband with the degenerate flag and numerator signs filled in
	always_comb begin
		side_c2       = side_s1;
		side_c2.degen = degen_c;
		side_c2.neg   = neg_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_vld_s[0] <= 1'b0;
		else if (en)
			sq_vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side_s[0]       <= side_c2;
			sq_v_s[0]          <= degen_c ? '0 :
				SQ_IN_W'({rad_s1[RAD_W-2:0], ROT_FRAC_BITS'(0)});
			sq_rem_s[0]        <= '0;
			sq_root_s[0]       <= '0;
			for (int k = 0; k < LANES; k++)
				sq_mag_s[0][k] <= DIV_W'({abs_c[k][RAD_W-2:0], ROT_FRAC_BITS'(0)});
		end
	end

	// square root, one result bit per stage
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		logic [SQ_REM_W+1:0] rem_t;
		logic [SQ_REM_W+1:0] trial;
		logic                take;
		assign rem_t = {sq_rem_s[i], sq_v_s[i][SQ_IN_W-1 -: 2]};
		assign trial = (SQ_REM_W+2)'({sq_root_s[i], 2'b01});
		assign take  = rem_t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_vld_s[i+1] <= 1'b0;
			else if (en)
				sq_vld_s[i+1] <= sq_vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[i+1]  <= take ? SQ_REM_W'(rem_t - trial) : SQ_REM_W'(rem_t);
				sq_root_s[i+1] <= {sq_root_s[i][ROOT_W-2:0], take};
				sq_v_s[i+1]    <= {sq_v_s[i][SQ_IN_W-3:0], 2'b00};
				sq_side_s[i+1] <= sq_side_s[i];
				sq_mag_s[i+1]  <= sq_mag_s[i];
			end
		end
	end

	// divider operands: rounded quotient of (mag + s) / 2s
	logic [ROOT_W-1:0] root;
	logic [ROOT_W:0]   big_sum;
	side_t             side_dv;
	logic [DIV_W-1:0]  quo [LANES];

	assign root    = sq_root_s[SQ_STEPS];
	assign big_sum = {1'b0, root} + (ROOT_W+1)'(1);

	always_comb begin
		side_dv     = sq_side_s[SQ_STEPS];
		side_dv.big = big_sum[ROOT_W:1];
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		rmq_div_pipe u_div (
			.clk      (clk),
			.en       (en),
			.dividend (sq_mag_s[SQ_STEPS][k] + DIV_W'(root)),
			.divisor  ({root, 1'b0}),
			.quotient (quo[k])
		);
	end

	// sideband alongside the dividers
	logic  dv_vld_s  [0:DIV_W];
	side_t dv_side_s [0:DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_s[0] <= 1'b0;
		else if (en)
			dv_vld_s[0] <= sq_vld_s[SQ_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en)
			dv_side_s[0] <= side_dv;
	end

	for (genvar i = 0; i < DIV_W; i++) begin : g_dside
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[i+1] <= 1'b0;
			else if (en)
				dv_vld_s[i+1] <= dv_vld_s[i];
		end
		always_ff @(posedge clk) begin
			if (en)
				dv_side_s[i+1] <= dv_side_s[i];
		end
	end

	// sign, saturate and place the components
	side_t                   fin;
	logic signed [ROT_W-1:0] minor [LANES];
	logic signed [ROT_W-1:0] big_q;
	logic signed [ROT_W-1:0] qw_c, qx_c, qy_c, qz_c;

	assign fin   = dv_side_s[DIV_W];
	assign big_q = fin.big;

	always_comb begin
		for (int k = 0; k < LANES; k++)
			minor[k] = sat16(fin.neg[k] ? -$signed({2'b00, quo[k]}) :
				$signed({2'b00, quo[k]}));
	end

	always_comb begin
		if (fin.degen) begin
			qw_c = ROT_W'(ONE);
			qx_c = '0;
			qy_c = '0;
			qz_c = '0;
		end else begin
			case (fin.major)
				MAJ_W: begin
					qw_c = big_q;
					qx_c = minor[0];
					qy_c = minor[1];
					qz_c = minor[2];
				end
				MAJ_X: begin
					qw_c = minor[0];
					qx_c = big_q;
					qy_c = minor[1];
					qz_c = minor[2];
				end
				MAJ_Y: begin
					qw_c = minor[0];
					qx_c = minor[1];
					qy_c = big_q;
					qz_c = minor[2];
				end
				default: begin
					qw_c = minor[0];
					qx_c = minor[1];
					qy_c = minor[2];
					qz_c = big_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= dv_vld_s[DIV_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.pos_x      <= fin.pos_x;
			result.pos_y      <= fin.pos_y;
			result.pos_z      <= fin.pos_z;
			result.quat_w     <= qw_c;
			result.quat_x     <= qx_c;
			result.quat_y     <= qy_c;
			result.quat_z     <= qz_c;
			result.degenerate <= fin.degen;
		end
	end

	assign result.valid = out_vld_q;

`ifndef SYNTHESIS
	// degenerate results carry the identity quaternion
	a_degen_identity: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |->
		result.quat_w == ROT_W'(ONE) && result.quat_x == '0 &&
		result.quat_y == '0 && result.quat_z == '0)
		else $error("degenerate result without identity quaternion");

	// the trace branch always has a positive radicand
	a_degen_branch: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld_s[0] && sq_side_s[0].degen |-> sq_side_s[0].major != MAJ_W)
		else $error("degenerate radicand on trace branch");

	// an item leaving the dividers lands in the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		en && dv_vld_s[DIV_W] |=> result.valid)
		else $error("item dropped at output register");
`endif

endmodule
